FILE: design/gpm_pkg.sv
package gpm_pkg;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_NAME    = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [8:0] LAST_NONE = 9'h100;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEP_RD,
    ST_SEP_CHK,
    ST_ALT_INIT,
    ST_COL_RD,
    ST_COL_DEC,
    ST_COL_EXE,
    ST_CLS_RD,
    ST_CLS_CHK,
    ST_CLS_RNG,
    ST_CLS_FIN,
    ST_ALT_DONE,
    ST_EMIT
  } gpm_state_e;

endpackage

FILE: design/gpm_front.sv
module gpm_front
  import gpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  output in_item_t q_item_o,
  input  logic     q_pop_i
);

  in_item_t   buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  in_item_t   folded;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_q];

  // fold lower case to upper case
  always_comb begin
    folded = in_item_i;
    if (in_item_i.char_code >= CH_LOW_A && in_item_i.char_code <= CH_LOW_Z) begin
      folded.char_code = in_item_i.char_code - CASE_GAP;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= folded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

endmodule

FILE: design/gpm_back.sv
module gpm_back
  import gpm_pkg::*;
#(
  parameter int PATTERN_MAX = 64,
  parameter int NAME_MAX    = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  in_item_t  q_item_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int PW  = $clog2(PATTERN_MAX + 1);
  localparam int PIW = $clog2(PATTERN_MAX);
  localparam int NW  = $clog2(NAME_MAX + 1);
  localparam int NIW = $clog2(NAME_MAX);
  localparam logic [PW-1:0] PMAX_W = PW'(PATTERN_MAX);
  localparam logic [NW-1:0] NMAX_W = NW'(NAME_MAX);

  gpm_state_e st_q, st_d;

  logic [PW-1:0]   plen_q, plen_d, start_q, start_d, end_q, end_d;
  logic [PW-1:0]   pi_q, pi_d, q_q, q_d;
  logic            pdone_q, pdone_d, povf_q, povf_d, ndrop_q, ndrop_d;
  logic            rev_q, rev_d, found_q, found_d;
  logic [NW-1:0]   nlen_q, nlen_d;
  logic [8:0]      last_q, last_d;
  logic [7:0]      c_q, c_d;
  logic [NAME_MAX-1:0] hit_q, hit_d, hit_eq, hit_rng;
  logic [NAME_MAX:0]   col1_q, col1_d, col2_q, col2_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic [7:0]        nm_q [NAME_MAX];
  logic [7:0]        pmem [PATTERN_MAX];
  logic [7:0]        prd_q;
  logic [NAME_MAX:0] cmem [PATTERN_MAX+1];
  logic [NAME_MAX:0] crd_q;

  logic              pwe, cwe, nwe;
  logic [PW-1:0]     pwa, pa, cwa, cra, base;
  logic [7:0]        pwd;
  logic [NAME_MAX:0] cwd;

  logic pi_last, nx_in, alt_last, slot_free, q_end, q1_end, star_last, is_cls, is_sep;
  logic commit, advance;
  logic [NAME_MAX:0] new_col, exe_col, sfx;
  logic [NAME_MAX:0] col_star, col_any, col_lit1, col_lit2, col_unterm, col_closed, col_init;

  assign pi_last   = (pi_q == start_q);
  assign nx_in     = ((pi_q + PW'(1)) < end_q);
  assign alt_last  = (end_q == plen_q);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign q_end     = (q_q >= end_q);
  assign q1_end    = ((q_q + PW'(1)) >= end_q);
  assign star_last = ((pi_q + PW'(1)) == end_q);
  assign is_cls    = (c_q == CH_LBRK);
  assign is_sep    = (prd_q == CH_COMMA) || (prd_q == CH_SEMI);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // per-name-position lanes
  always_comb begin
    sfx[NAME_MAX] = 1'b0;
    for (int i = NAME_MAX - 1; i >= 0; i--) begin
      sfx[i] = sfx[i+1] | (col1_q[i] & (NW'(i) < nlen_q));
    end
    for (int i = 0; i < NAME_MAX; i++) begin
      col_any[i]    = (NW'(i) < nlen_q) & col1_q[i+1];
      col_lit1[i]   = (NW'(i) < nlen_q) & (nm_q[i] == c_q) & col1_q[i+1];
      col_lit2[i]   = (NW'(i) < nlen_q) & (nm_q[i] == prd_q) & col2_q[i+1];
      col_unterm[i] = (NW'(i) < nlen_q) & (hit_q[i] ^ rev_q) & (NW'(i + 1) == nlen_q);
      col_closed[i] = (NW'(i) < nlen_q) & (hit_q[i] ^ rev_q) & crd_q[i+1];
      col_star[i]   = (NW'(i) < nlen_q) ? (star_last | sfx[i])
                                        : ((NW'(i) == nlen_q) & star_last);
      hit_eq[i]     = (nm_q[i] == prd_q);
      hit_rng[i]    = (nm_q[i] <= prd_q) && ({1'b0, nm_q[i]} >= last_q);
    end
    for (int i = 0; i <= NAME_MAX; i++) begin
      col_init[i] = (NW'(i) == nlen_q);
    end
    col_any[NAME_MAX]    = 1'b0;
    col_lit1[NAME_MAX]   = 1'b0;
    col_lit2[NAME_MAX]   = 1'b0;
    col_unterm[NAME_MAX] = 1'b0;
    col_closed[NAME_MAX] = 1'b0;
    col_star[NAME_MAX]   = (NMAX_W == nlen_q) & star_last;
  end

  always_comb begin
    case (c_q)
      CH_STAR:  exe_col = col_star;
      CH_QMARK: exe_col = col_any;
      CH_AT:    exe_col = nx_in ? col_lit2 : col_lit1;
      default:  exe_col = col_lit1;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i && q_item_i.cmd == CMD_NAME && q_item_i.final_char) begin
          st_d = ST_SEP_RD;
        end
      end
      ST_SEP_RD:   st_d = alt_last ? ST_ALT_INIT : ST_SEP_CHK;
      ST_SEP_CHK:  st_d = is_sep ? ST_ALT_INIT : ST_SEP_RD;
      ST_ALT_INIT: begin
        if (end_q > start_q) begin
          st_d = ST_COL_RD;
        end else begin
          st_d = alt_last ? ST_EMIT : ST_SEP_RD;
        end
      end
      ST_COL_RD:  st_d = ST_COL_DEC;
      ST_COL_DEC: st_d = ST_COL_EXE;
      ST_COL_EXE: begin
        if (is_cls) begin
          st_d = ST_CLS_RD;
        end else begin
          st_d = pi_last ? ST_ALT_DONE : ST_COL_RD;
        end
      end
      ST_CLS_RD: begin
        if (q_end) begin
          st_d = pi_last ? ST_ALT_DONE : ST_COL_RD;
        end else begin
          st_d = ST_CLS_CHK;
        end
      end
      ST_CLS_CHK: begin
        if (prd_q == CH_RBRK) begin
          st_d = ST_CLS_FIN;
        end else if (prd_q == CH_DASH) begin
          if (q1_end) begin
            st_d = pi_last ? ST_ALT_DONE : ST_COL_RD;
          end else begin
            st_d = ST_CLS_RNG;
          end
        end else begin
          st_d = ST_CLS_RD;
        end
      end
      ST_CLS_RNG: st_d = ST_CLS_RD;
      ST_CLS_FIN: st_d = pi_last ? ST_ALT_DONE : ST_COL_RD;
      ST_ALT_DONE: begin
        if (col1_q[0] || alt_last) begin
          st_d = ST_EMIT;
        end else begin
          st_d = ST_SEP_RD;
        end
      end
      ST_EMIT: st_d = slot_free ? ST_IDLE : ST_EMIT;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    plen_d = plen_q;   start_d = start_q; end_d = end_q;   pi_d = pi_q;
    q_d = q_q;         pdone_d = pdone_q; povf_d = povf_q; ndrop_d = ndrop_q;
    rev_d = rev_q;     found_d = found_q; nlen_d = nlen_q; last_d = last_q;
    c_d = c_q;         hit_d = hit_q;     col1_d = col1_q; col2_d = col2_q;
    out_d = out_q;
    out_valid_d = out_valid_q;
    pwe = 1'b0; pwa = '0; pwd = '0; pa = '0;
    cwe = 1'b0; cwa = '0; cwd = '0; cra = '0;
    nwe = 1'b0; q_pop_o = 1'b0;
    commit = 1'b0; advance = 1'b0; new_col = '0;
    base = pdone_q ? '0 : plen_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.cmd == CMD_PATTERN) begin
            q_pop_o = 1'b1;
            if (base < PMAX_W) begin
              pwe    = 1'b1;
              pwa    = base;
              pwd    = q_item_i.char_code;
              plen_d = base + PW'(1);
              povf_d = pdone_q ? 1'b0 : povf_q;
            end else begin
              plen_d = base;
              povf_d = 1'b1;
            end
            pdone_d = q_item_i.final_char;
          end else begin
            if (nlen_q < NMAX_W) begin
              nwe    = 1'b1;
              nlen_d = nlen_q + NW'(1);
            end else begin
              ndrop_d = 1'b1;
            end
            if (!q_item_i.final_char) begin
              q_pop_o = 1'b1;
            end else begin
              start_d = '0;
              end_d   = '0;
              found_d = 1'b0;
            end
          end
        end
      end
      ST_SEP_RD: pa = end_q;
      ST_SEP_CHK: begin
        if (!is_sep) begin
          end_d = end_q + PW'(1);
        end
      end
      ST_ALT_INIT: begin
        if (end_q > start_q) begin
          col1_d = col_init;
          cwe    = 1'b1;
          cwa    = end_q;
          cwd    = col_init;
          pi_d   = end_q - PW'(1);
        end else begin
          advance = 1'b1;
        end
      end
      ST_COL_RD: pa = pi_q;
      ST_COL_DEC: begin
        c_d = prd_q;
        pa  = pi_q + PW'(1);
      end
      ST_COL_EXE: begin
        if (is_cls) begin
          rev_d  = nx_in && (prd_q == CH_CARET);
          q_d    = pi_q + PW'(1) + {{(PW-1){1'b0}}, nx_in && (prd_q == CH_CARET)};
          hit_d  = '0;
          last_d = LAST_NONE;
        end else begin
          commit  = 1'b1;
          new_col = exe_col;
        end
      end
      ST_CLS_RD: begin
        if (q_end) begin
          commit  = 1'b1;
          new_col = col_unterm;
        end else begin
          pa = q_q;
        end
      end
      ST_CLS_CHK: begin
        if (prd_q == CH_RBRK) begin
          cra = q_q + PW'(1);
        end else if (prd_q == CH_DASH) begin
          if (q1_end) begin
            commit  = 1'b1;
            new_col = col_unterm;
          end else begin
            pa = q_q + PW'(1);
          end
        end else begin
          hit_d  = hit_q | hit_eq;
          last_d = {1'b0, prd_q};
          q_d    = q_q + PW'(1);
        end
      end
      ST_CLS_RNG: begin
        hit_d  = hit_q | hit_rng;
        last_d = {1'b0, prd_q};
        q_d    = q_q + PW'(2);
      end
      ST_CLS_FIN: begin
        commit  = 1'b1;
        new_col = col_closed;
      end
      ST_ALT_DONE: begin
        if (col1_q[0]) begin
          found_d = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_d.matched  = found_q;
          out_d.overflow = povf_q | ndrop_q;
          out_valid_d    = 1'b1;
          q_pop_o        = 1'b1;
          nlen_d         = '0;
          ndrop_d        = 1'b0;
        end
      end
      default: ;
    endcase

    if (commit) begin
      cwe    = 1'b1;
      cwa    = pi_q;
      cwd    = new_col;
      col2_d = col1_q;
      col1_d = new_col;
      if (!pi_last) begin
        pi_d = pi_q - PW'(1);
      end
    end
    if (advance && !alt_last) begin
      start_d = end_q + PW'(1);
      end_d   = end_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem[pwa[PIW-1:0]] <= pwd;
    end
    if (pa < PMAX_W) begin
      prd_q <= pmem[pa[PIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cwe) begin
      cmem[cwa] <= cwd;
    end
    crd_q <= cmem[cra];
  end

  always_ff @(posedge clk_i) begin
    if (nwe) begin
      nm_q[nlen_q[NIW-1:0]] <= q_item_i.char_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      plen_q      <= '0;
      start_q     <= '0;
      end_q       <= '0;
      pi_q        <= '0;
      q_q         <= '0;
      pdone_q     <= 1'b1;
      povf_q      <= 1'b0;
      ndrop_q     <= 1'b0;
      rev_q       <= 1'b0;
      found_q     <= 1'b0;
      nlen_q      <= '0;
      last_q      <= LAST_NONE;
      c_q         <= '0;
      hit_q       <= '0;
      col1_q      <= '0;
      col2_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      plen_q      <= plen_d;
      start_q     <= start_d;
      end_q       <= end_d;
      pi_q        <= pi_d;
      q_q         <= q_d;
      pdone_q     <= pdone_d;
      povf_q      <= povf_d;
      ndrop_q     <= ndrop_d;
      rev_q       <= rev_d;
      found_q     <= found_d;
      nlen_q      <= nlen_d;
      last_q      <= last_d;
      c_q         <= c_d;
      hit_q       <= hit_d;
      col1_q      <= col1_d;
      col2_q      <= col2_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/glob_pattern_matcher.sv
// Wildcard filter: send pattern characters (cmd 0), then name characters (cmd 1); the
// name character with final_char set yields one item telling whether the name matches
// any comma- or semicolon-separated alternative, plus a flag for dropped characters.
// Every pattern character and every name character other than the last is popped as soon as it heads the queue.
// The last name character starts a match sequencer sharing the single pattern memory
// read port: it reads and checks each pattern character to find separators, reads,
// decodes and executes each position of every non-empty alternative, scans the class
// characters each time a '[' position is evaluated (with an extra step per range and
// for the closing ']'), and then delivers the result; a full match ends the walk early.
// The last name character stays at the head of a two-entry input queue during the
// walk, so one further item is taken before the input stalls.
module glob_pattern_matcher
  import gpm_pkg::*;
#(
  parameter int PATTERN_MAX = 64,
  parameter int NAME_MAX    = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     q_valid, q_pop;
  in_item_t q_item;

  gpm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  gpm_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .NAME_MAX    (NAME_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop && q_item.cmd == CMD_NAME && q_item.final_char))
    else $error("result without final name item");

  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_item.cmd == CMD_NAME && q_item.final_char) |=> out_valid_o)
    else $error("final name item retired without result");
`endif

endmodule
